/* rtl/sed_pkg.sv */
package sed_pkg;

  // Character codes used by the decoder
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_B   = 8'h62;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_T   = 8'h74;
  localparam logic [7:0] CH_LC_V   = 8'h76;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // Decoded control codes
  localparam logic [7:0] CODE_BEL = 8'd7;
  localparam logic [7:0] CODE_BS  = 8'd8;
  localparam logic [7:0] CODE_HT  = 8'd9;
  localparam logic [7:0] CODE_LF  = 8'd10;
  localparam logic [7:0] CODE_VT  = 8'd11;
  localparam logic [7:0] CODE_FF  = 8'd12;
  localparam logic [7:0] CODE_CR  = 8'd13;

  localparam int unsigned MAX_RESULTS = 3;

  // Escape tracking state carried between bytes
  typedef struct packed {
    logic       in_escape;
    logic [1:0] digit_count;
    logic [9:0] digit_value;
  } esc_state_t;

  // One decoded output byte with its flags
  typedef struct packed {
    logic [7:0] ch;
    logic       too_large;
    logic       unknown;
    logic       term;
    logic       run_end;
  } result_t;

  // Letter/punctuation escape: returns {unknown, code}
  function automatic logic [8:0] letter_escape(input logic [7:0] c);
    logic [8:0] r;
    r = {1'b0, c};
    case (c)
      CH_SQUOTE, CH_DQUOTE, CH_QMARK, CH_BSLASH: r = {1'b0, c};
      CH_LC_A: r = {1'b0, CODE_BEL};
      CH_LC_B: r = {1'b0, CODE_BS};
      CH_LC_F: r = {1'b0, CODE_FF};
      CH_LC_N: r = {1'b0, CODE_LF};
      CH_LC_R: r = {1'b0, CODE_CR};
      CH_LC_T: r = {1'b0, CODE_HT};
      CH_LC_V: r = {1'b0, CODE_VT};
      default: r = {1'b1, c};
    endcase
    return r;
  endfunction

endpackage

/* rtl/sed_decode.sv */
module sed_decode
  import sed_pkg::*;
#(
  parameter int unsigned MAX_ESCAPE_DIGITS = 3
) (
  input  esc_state_t st_i,
  input  logic [7:0] char_i,
  input  logic       final_i,
  output esc_state_t st_o,
  output result_t    res_o [MAX_RESULTS],
  output logic [1:0] cnt_o
);

  localparam logic [1:0] MaxDigits = 2'(MAX_ESCAPE_DIGITS);

  logic       is_digit;
  logic [9:0] acc_value;
  logic [1:0] acc_count;
  logic [8:0] letter;
  logic [1:0] n;
  esc_state_t nxt;
  result_t    res [MAX_RESULTS];

  assign is_digit  = (char_i >= CH_ZERO) && (char_i <= CH_NINE);
  assign acc_value = 10'({st_i.digit_value, 3'b000} + {2'b00, st_i.digit_value, 1'b0}
                         + 13'(char_i[3:0]));
  assign acc_count = st_i.digit_count + 2'd1;
  assign letter    = letter_escape(char_i);

  // Build the result list for one byte in order
  always_comb begin
    nxt = st_i;
    n   = 2'd0;
    for (int k = 0; k < MAX_RESULTS; k++) begin
      res[k] = '0;
    end

    if (!st_i.in_escape) begin
      if (char_i == CH_BSLASH) begin
        nxt.in_escape = 1'b1;
      end else begin
        res[n].ch = char_i;
        n = n + 2'd1;
      end
    end else if (is_digit) begin
      nxt.digit_value = acc_value;
      nxt.digit_count = acc_count;
      if (acc_count >= MaxDigits || final_i) begin
        res[n].ch        = acc_value[7:0];
        res[n].too_large = acc_value > 10'd255;
        n   = n + 2'd1;
        nxt = '0;
      end
    end else if (st_i.digit_count != 2'd0) begin
      // flush collected digits, then treat this byte as ordinary
      res[n].ch        = st_i.digit_value[7:0];
      res[n].too_large = st_i.digit_value > 10'd255;
      n   = n + 2'd1;
      nxt = '0;
      if (char_i == CH_BSLASH) begin
        nxt.in_escape = 1'b1;
      end else begin
        res[n].ch = char_i;
        n = n + 2'd1;
      end
    end else begin
      res[n].ch      = letter[7:0];
      res[n].unknown = letter[8];
      n = n + 2'd1;
      nxt.in_escape = 1'b0;
    end

    // closing zero byte at end of literal
    if (final_i) begin
      res[n].ch   = CH_NUL;
      res[n].term = 1'b1;
      n   = n + 2'd1;
      nxt = '0;
    end

    if (n != 2'd0) begin
      res[n - 2'd1].run_end = 1'b1;
    end
  end

  assign st_o  = nxt;
  assign res_o = res;
  assign cnt_o = n;

endmodule

/* rtl/string_escape_decoder.sv */
// The first result of a byte is presented the cycle after the byte is accepted.
// One byte per cycle is taken when each byte gives at most one result and the
// output is not stalled; a byte that gives more results holds off new bytes
// while the result buffer drains.
// Reset: rst_ni clears the escape state and the result count; no result is pending.
module string_escape_decoder
  import sed_pkg::*;
#(
  parameter int unsigned MAX_ESCAPE_DIGITS = 3
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_char_i,
  input  logic       in_final_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic       escape_too_large_o,
  output logic       escape_unknown_o,
  output logic       terminator_o,
  output logic       run_end_o
);

  esc_state_t state_q, state_d;
  result_t    res_q [MAX_RESULTS];
  result_t    res_d [MAX_RESULTS];
  logic [1:0] buf_cnt_q;
  logic [1:0] new_cnt;
  logic       accept;
  logic       pop;

  sed_decode #(
    .MAX_ESCAPE_DIGITS(MAX_ESCAPE_DIGITS)
  ) u_decode (
    .st_i   (state_q),
    .char_i (in_char_i),
    .final_i(in_final_i),
    .st_o   (state_d),
    .res_o  (res_d),
    .cnt_o  (new_cnt)
  );

  // Handshake: take a new byte once the buffer is empty or draining its last entry
  assign pop        = out_valid_o && out_ready_i;
  assign in_ready_o = (buf_cnt_q == 2'd0) || ((buf_cnt_q == 2'd1) && out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  // Escape state and buffer occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= '0;
      buf_cnt_q <= 2'd0;
    end else begin
      if (accept) begin
        state_q   <= state_d;
        buf_cnt_q <= new_cnt;
      end else if (pop) begin
        buf_cnt_q <= buf_cnt_q - 2'd1;
      end
    end
  end

  // Result buffer: head at slot 0, shifts down on each output transfer unless a new byte is loaded
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end else if (pop) begin
      res_q[0] <= res_q[1];
      res_q[1] <= res_q[2];
    end
  end

  assign out_valid_o        = buf_cnt_q != 2'd0;
  assign out_char_o         = res_q[0].ch;
  assign escape_too_large_o = res_q[0].too_large;
  assign escape_unknown_o   = res_q[0].unknown;
  assign terminator_o       = res_q[0].term;
  assign run_end_o          = res_q[0].run_end;

`ifndef SYNTH
  // digits are only collected inside an open escape
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !state_q.in_escape |-> (state_q.digit_count == 2'd0 && state_q.digit_value == 10'd0))
    else $error("digit state set outside an escape");

  // a partial digit run never reaches the limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.digit_count < 2'(MAX_ESCAPE_DIGITS))
    else $error("digit count reached limit without flush");

  // the last buffered result closes the run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !run_end_o) |-> (buf_cnt_q >= 2'd2))
    else $error("run_end missing on last buffered result");

  // terminator is always the last result of its byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && terminator_o) |-> run_end_o)
    else $error("terminator without run_end");
`endif

endmodule
